[rtl/u7tr_pkg.sv]
// ----------------------------------------------------------------------------
// u7tr_pkg: shared types and constants for the 7N1 serial transmitter/receiver
// Holds the item kinds, the input and result beat layouts and the defaults
// of the top-level parameters.
// ----------------------------------------------------------------------------
package u7tr_pkg;

  // Character width seen on the ports.
  localparam int unsigned CHAR_W = 7;

  // Parameter defaults.
  localparam int unsigned DATA_BITS_DEF  = 7;
  localparam int unsigned OVERSAMPLE_DEF = 16;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_TX_TICK = 2'd1,
    KIND_RX_TICK = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] tx_byte;
    logic              rx_line;
  } in_t;

  typedef struct packed {
    logic              tx_line;
    logic              rx_valid;
    logic [CHAR_W-1:0] rx_byte;
  } out_t;

  // Receiver result for one beat.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] rx_byte;
  } rx_res_t;

endpackage

[rtl/u7tr_tx.sv]
// ----------------------------------------------------------------------------
// u7tr_tx: transmit frame sequencer
// Steps idle/start/data/stop on each transmit tick and reports the line
// level that results from the current beat.
// ----------------------------------------------------------------------------
module u7tr_tx
  import u7tr_pkg::*;
#(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  output logic tx_line_o
);

  localparam int unsigned RemW = $clog2(DATA_BITS + 1);
  localparam int unsigned ExtW = (DATA_BITS > CHAR_W) ? DATA_BITS : CHAR_W;

  typedef enum logic [1:0] {
    TX_IDLE,
    TX_START,
    TX_DATA,
    TX_STOP
  } tx_phase_e;

  tx_phase_e            phase_q, phase_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic                 level_q, level_d;
  logic [ExtW-1:0]      load_ext;

  assign load_ext = ExtW'(item_i.tx_byte);

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    level_d = level_q;
    case (item_i.kind)
      KIND_LOAD: begin
        // Restart the frame; the line holds until the next tick.
        shift_d = load_ext[DATA_BITS-1:0];
        rem_d   = RemW'(DATA_BITS);
        phase_d = TX_START;
      end
      KIND_TX_TICK: begin
        unique case (phase_q)
          TX_START: begin
            level_d = 1'b0;
            phase_d = TX_DATA;
          end
          TX_DATA: begin
            level_d = shift_q[0];
            shift_d = shift_q >> 1;
            if (rem_q <= RemW'(1)) begin
              rem_d   = '0;
              phase_d = TX_STOP;
            end else begin
              rem_d = rem_q - RemW'(1);
            end
          end
          default: begin
            level_d = 1'b1;
            phase_d = TX_IDLE;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= TX_IDLE;
      shift_q <= '0;
      rem_q   <= '0;
      level_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      level_q <= level_d;
    end
  end

  assign tx_line_o = level_d;

endmodule

[rtl/u7tr_rx.sv]
// ----------------------------------------------------------------------------
// u7tr_rx: oversampled receive sequencer
// Finds a low line, waits to mid start bit, then takes one data bit every
// oversample period and flags the character on the beat that takes the last data bit.
// ----------------------------------------------------------------------------
module u7tr_rx
  import u7tr_pkg::*;
#(
  parameter int unsigned DATA_BITS  = DATA_BITS_DEF,
  parameter int unsigned OVERSAMPLE = OVERSAMPLE_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  in_t     item_i,
  output rx_res_t res_o
);

  localparam int unsigned WaitW = $clog2(OVERSAMPLE);
  localparam int unsigned CntW  = $clog2(DATA_BITS + 1);
  localparam int unsigned ExtW  = (DATA_BITS > CHAR_W) ? DATA_BITS : CHAR_W;
  localparam logic [WaitW-1:0] HALF_WAIT = WaitW'(OVERSAMPLE / 2 - 1);
  localparam logic [WaitW-1:0] FULL_WAIT = WaitW'(OVERSAMPLE - 1);

  typedef enum logic [1:0] {
    RX_EDGE,
    RX_START,
    RX_DATA,
    RX_STOP
  } rx_phase_e;

  rx_phase_e            phase_q, phase_d;
  logic [WaitW-1:0]     wait_q, wait_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic                 done;
  logic [ExtW-1:0]      shift_ext;

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    done    = 1'b0;
    if (item_i.kind == KIND_RX_TICK) begin
      if (wait_q != '0) begin
        wait_d = wait_q - WaitW'(1);
      end else begin
        unique case (phase_q)
          RX_EDGE: begin
            if (!item_i.rx_line) begin
              phase_d = RX_START;
              wait_d  = HALF_WAIT;
            end
          end
          RX_START: begin
            phase_d = RX_DATA;
            wait_d  = FULL_WAIT;
            cnt_d   = '0;
            shift_d = '0;
          end
          RX_DATA: begin
            // Drop the sample into the bit slot picked by the count.
            for (int i = 0; i < DATA_BITS; i++) begin
              if (cnt_q == CntW'(i)) begin
                shift_d[i] = shift_q[i] | item_i.rx_line;
              end
            end
            cnt_d  = cnt_q + CntW'(1);
            wait_d = FULL_WAIT;
            if (cnt_d >= CntW'(DATA_BITS)) begin
              phase_d = RX_STOP;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = RX_EDGE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RX_EDGE;
      wait_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

  assign shift_ext     = ExtW'(shift_d);
  assign res_o.valid   = done;
  assign res_o.rx_byte = done ? shift_ext[CHAR_W-1:0] : '0;

endmodule

[rtl/uart_7n1_tx_rx.sv]
// ----------------------------------------------------------------------------
// uart_7n1_tx_rx: 7N1 serial transmitter and 16x oversampled receiver
// Each input beat is a load, a transmit tick or a receive sample tick; each
// beat yields one result beat with the line level and any received character.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the skid register is free; the state
//   update of both sequencers is a single short combinational step between
//   state and result registers.
// A two-entry output stage (result register plus skid register) lets input
//   beats keep flowing while a result waits; input stalls only once the skid
//   register holds a beat.
// Reset: asynchronous, active low; both sequencers go idle, tx line high.
module uart_7n1_tx_rx
  import u7tr_pkg::*;
#(
  parameter int unsigned DATA_BITS  = DATA_BITS_DEF,
  parameter int unsigned OVERSAMPLE = OVERSAMPLE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic    in_fire;
  logic    out_fire;
  logic    tx_line;
  rx_res_t rx_res;
  out_t    res_new;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  out_t    main_q, main_d;
  out_t    skid_q, skid_d;

  // Accept while the skid register is free; that flag is registered, so
  // stall never depends on this cycle's output handshake.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = main_valid_q && !out_stall_i;

  u7tr_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .item_i    (in_data_i),
    .tx_line_o (tx_line)
  );

  u7tr_rx #(
    .DATA_BITS  (DATA_BITS),
    .OVERSAMPLE (OVERSAMPLE)
  ) u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .item_i (in_data_i),
    .res_o  (rx_res)
  );

  assign res_new.tx_line  = tx_line;
  assign res_new.rx_valid = rx_res.valid;
  assign res_new.rx_byte  = rx_res.rx_byte;

  // Output stage: refill the result register from the skid register first,
  // else from the new beat; park the new beat in skid while output stalls.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (out_fire || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = in_fire;
        main_d       = res_new;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_d       = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // The skid register only fills behind a held result.
  a_skid_behind_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid beat held with empty result register");

  // A beat accepted against a stalled result must land in the skid register.
  a_park_in_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && out_stall_i && in_fire) |=> skid_valid_q)
    else $error("accepted beat lost behind stalled result");

  // Draining the result register moves the skid beat forward.
  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && skid_valid_q) |=> (main_valid_q && !skid_valid_q))
    else $error("skid beat not moved into result register");

  // Only a receive sample tick can complete a character.
  a_rx_only_on_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.kind != KIND_RX_TICK)) |-> !rx_res.valid)
    else $error("character completed on a non-sample beat");

endmodule

[sim/uart_7n1_tx_rx_tb.sv]
// ----------------------------------------------------------------------------
// uart_7n1_tx_rx_tb: self-checking bench for the 7N1 serial transmitter/receiver
// Walks a short table of hand-picked beats, then streams random serial frames,
// transmit bursts and noise. A behavioral copy of both sequencers predicts the
// untyped results; each result beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module uart_7n1_tx_rx_tb;
  import u7tr_pkg::*;

  // Kind code that the block ignores; sent on purpose.
  localparam kind_e KIND_UNUSED = kind_e'(2'd3);

  localparam logic [3:0] HALF_BIT_WAIT = 4'(OVERSAMPLE_DEF / 2 - 1);
  localparam logic [3:0] FULL_BIT_WAIT = 4'(OVERSAMPLE_DEF - 1);

  localparam int unsigned RAND_ITEMS   = 650;
  localparam int unsigned HOLD_AT      = 200;  // receiver holds off here
  localparam int unsigned PAUSE_AT     = 400;  // sender drains the block here
  localparam int unsigned QUIET_AT     = RAND_ITEMS - 120;
  localparam int unsigned LONG_HOLD    = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  typedef enum logic [1:0] {TX_IDLE, TX_START, TX_DATA, TX_STOP} tx_phase_e;
  typedef enum logic [1:0] {RX_HUNT, RX_START, RX_DATA, RX_STOP} rx_phase_e;

  // One row of the directed table: the beat, and a typed-in result where it
  // is obvious; otherwise the predictor supplies the expectation.
  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t res;
  } row_t;

  localparam out_t LINE_HI = '{1'b1, 1'b0, 7'h00};
  localparam out_t LINE_LO = '{1'b0, 1'b0, 7'h00};

  localparam int unsigned N_DIRECTED = 25;
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // out of reset: line idles high, nothing received
    '{'{KIND_RX_TICK, 7'h00, 1'b1}, 1'b1, LINE_HI},
    '{'{KIND_UNUSED,  7'h7F, 1'b1}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    // all-ones character: start, seven marks, stop, idle
    '{'{KIND_LOAD,    7'h7F, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_LO},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_HI},
    // all-zeros character, then a reload in the middle of its frame
    '{'{KIND_LOAD,    7'h00, 1'b1}, 1'b1, LINE_HI},
    '{'{KIND_TX_TICK, 7'h7F, 1'b1}, 1'b1, LINE_LO},
    '{'{KIND_TX_TICK, 7'h7F, 1'b1}, 1'b1, LINE_LO},
    '{'{KIND_TX_TICK, 7'h7F, 1'b1}, 1'b1, LINE_LO},
    '{'{KIND_LOAD,    7'h55, 1'b0}, 1'b1, LINE_LO},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b1, LINE_LO},
    '{'{KIND_TX_TICK, 7'h00, 1'b0}, 1'b0, LINE_HI},
    '{'{KIND_TX_TICK, 7'h2A, 1'b1}, 1'b0, LINE_HI},
    // receiver: find a low line, then keep sampling around it
    '{'{KIND_RX_TICK, 7'h00, 1'b0}, 1'b0, LINE_HI},
    '{'{KIND_UNUSED,  7'h00, 1'b0}, 1'b0, LINE_HI},
    '{'{KIND_RX_TICK, 7'h7F, 1'b1}, 1'b0, LINE_HI},
    '{'{KIND_RX_TICK, 7'h00, 1'b0}, 1'b0, LINE_HI}
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_beat   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_beat;

  // Beat-level expectations, oldest first, and the beats still to be sent.
  out_t line_char_q [$];
  in_t  stim_q [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic        idle_on     = 1'b1;
  logic        hold_req    = 1'b0;

  // Predictor state: transmit and receive sequencers.
  tx_phase_e         tx_phase;
  logic [CHAR_W-1:0] tx_shift;
  logic [2:0]        tx_left;
  logic              tx_level;
  rx_phase_e         rx_phase;
  logic [3:0]        rx_wait;
  logic [2:0]        rx_bits;
  logic [CHAR_W-1:0] rx_shift;

  uart_7n1_tx_rx u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_model();
    tx_phase = TX_IDLE;
    tx_shift = '0;
    tx_left  = '0;
    tx_level = 1'b1;
    rx_phase = RX_HUNT;
    rx_wait  = '0;
    rx_bits  = '0;
    rx_shift = '0;
  endfunction

  // Advance both sequencers by one beat and return the line level and any
  // completed character.
  function automatic out_t serial_step(in_t b);
    out_t r;
    r = '0;
    case (b.kind)
      KIND_LOAD: begin
        // restart from the start bit; the line keeps its level for now
        tx_shift = b.tx_byte;
        tx_left  = 3'(DATA_BITS_DEF);
        tx_phase = TX_START;
      end
      KIND_TX_TICK: begin
        case (tx_phase)
          TX_START: begin
            tx_level = 1'b0;
            tx_phase = TX_DATA;
          end
          TX_DATA: begin
            tx_level = tx_shift[0];
            tx_shift = tx_shift >> 1;
            if (tx_left <= 3'd1) begin
              tx_left  = '0;
              tx_phase = TX_STOP;
            end else begin
              tx_left = tx_left - 3'd1;
            end
          end
          default: begin
            tx_level = 1'b1;
            tx_phase = TX_IDLE;
          end
        endcase
      end
      KIND_RX_TICK: begin
        if (rx_wait != '0) begin
          rx_wait = rx_wait - 4'd1;
        end else begin
          case (rx_phase)
            RX_HUNT: begin
              if (!b.rx_line) begin
                rx_phase = RX_START;
                rx_wait  = HALF_BIT_WAIT;
              end
            end
            RX_START: begin
              // mid start bit, level not checked
              rx_phase = RX_DATA;
              rx_wait  = FULL_BIT_WAIT;
              rx_bits  = '0;
              rx_shift = '0;
            end
            RX_DATA: begin
              rx_shift[rx_bits] = b.rx_line;
              rx_bits = rx_bits + 3'd1;
              rx_wait = FULL_BIT_WAIT;
              if (rx_bits == 3'(DATA_BITS_DEF)) begin
                rx_phase   = RX_STOP;
                r.rx_valid = 1'b1;
                r.rx_byte  = rx_shift;
              end
            end
            default: rx_phase = RX_HUNT;  // stop bit, level not checked
          endcase
        end
      end
      default: ;
    endcase
    r.tx_line = tx_level;
    return r;
  endfunction

  function automatic in_t make_beat(kind_e k, logic line);
    in_t b;
    b.kind    = k;
    b.tx_byte = 7'($urandom);
    b.rx_line = line;
    return b;
  endfunction

  // Queue one receive sample, now and then preceded by an unrelated beat.
  function automatic void push_rx_sample(logic line);
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      stim_q.push_back(make_beat(KIND_LOAD, 1'($urandom)));
    end else if (pick == 1) begin
      stim_q.push_back(make_beat(KIND_UNUSED, 1'($urandom)));
    end else if (pick <= 3) begin
      stim_q.push_back(make_beat(KIND_TX_TICK, 1'($urandom)));
    end
    stim_q.push_back(make_beat(KIND_RX_TICK, line));
  endfunction

  // Queue a serial frame at the oversampling rate: idle, start, data, stop.
  // Short glitches land on data bits away from the sampling point; cut drops
  // the tail to make a broken frame.
  function automatic void add_rx_frame(logic [CHAR_W-1:0] ch, int unsigned cut);
    logic [CHAR_W+1:0] frame_bits;
    logic              line;
    int unsigned       n;
    frame_bits = {1'b1, ch, 1'b0};
    n = 0;
    repeat ($urandom_range(1, 10)) push_rx_sample(1'b1);
    for (int i = 0; i < CHAR_W + 2; i++) begin
      for (int s = 0; s < OVERSAMPLE_DEF; s++) begin
        if (n == cut) return;
        line = frame_bits[i];
        if (i >= 1 && i <= CHAR_W && (s < 5 || s > 11) && $urandom_range(0, 15) == 0) begin
          line = ~line;
        end
        push_rx_sample(line);
        n++;
      end
    end
  endfunction

  // Offer one beat, hold it until taken, then record what it should produce.
  task automatic send_beat(input in_t b, input logic typed, input out_t typed_res);
    out_t predicted;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    predicted = serial_step(b);
    line_char_q.push_back(typed ? typed_res : predicted);
  endtask

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every taken result beat against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_char_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_beat);
        mismatches++;
      end else begin
        want = line_char_q.pop_front();
        if (out_beat.tx_line !== want.tx_line) begin
          $display("%0t: tx_line expected %0b, got %0b", $time, want.tx_line,
                   out_beat.tx_line);
          mismatches++;
        end
        if (out_beat.rx_valid !== want.rx_valid) begin
          $display("%0t: rx_valid expected %0b, got %0b", $time, want.rx_valid,
                   out_beat.rx_valid);
          mismatches++;
        end
        if (out_beat.rx_byte !== want.rx_byte) begin
          $display("%0t: rx_byte expected %h, got %h", $time, want.rx_byte,
                   out_beat.rx_byte);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned       sent_rand;
    int unsigned       full_frames;
    int unsigned       pick;
    logic [CHAR_W-1:0] last_ch;
    logic [CHAR_W-1:0] ch;
    in_t               b;

    sent_rand   = 0;
    full_frames = 0;
    last_ch     = '0;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_beat(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    end

    // Random episodes: whole and cut receive frames, transmit bursts and noise.
    while (sent_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5 && rx_phase != RX_HUNT) begin
        // let the receiver run out a misaligned frame before the next one
        repeat (OVERSAMPLE_DEF) push_rx_sample(1'b1);
      end else if (pick <= 4) begin
        // pair each character with its complement so every bit sees both values
        ch = full_frames[0] ? ~last_ch : 7'($urandom);
        add_rx_frame(ch, 32'hFFFF_FFFF);
        last_ch = ch;
        full_frames++;
      end else if (pick == 5) begin
        add_rx_frame(7'($urandom), $urandom_range(10, 120));
      end else if (pick <= 7) begin
        stim_q.push_back(make_beat(KIND_LOAD, 1'($urandom)));
        repeat ($urandom_range(1, 12)) begin
          stim_q.push_back(make_beat(KIND_TX_TICK, 1'($urandom)));
        end
      end else begin
        repeat ($urandom_range(4, 16)) begin
          stim_q.push_back(make_beat(kind_e'($urandom_range(0, 3)), 1'($urandom)));
        end
      end

      while (stim_q.size() != 0) begin
        b = stim_q.pop_front();
        send_beat(b, 1'b0, LINE_HI);
        if (b.kind != KIND_UNUSED) begin
          sent_rand++;
          if (sent_rand == HOLD_AT) hold_req = 1'b1;
          if (sent_rand == PAUSE_AT) begin
            // drop valid and wait for the block to empty out
            in_valid <= 1'b0;
            do @(posedge clk); while (line_char_q.size() != 0);
          end
          idle_on = sent_rand < QUIET_AT;
        end
      end
    end

    // Drain.
    in_valid <= 1'b0;
    while (line_char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && line_char_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/u7tr_pkg.sv
rtl/u7tr_tx.sv
rtl/u7tr_rx.sv
rtl/uart_7n1_tx_rx.sv
sim/uart_7n1_tx_rx_tb.sv
